FILE: rtl/horizontal_polyphase_resize_unit_assert.svh
// Assertion macros shared by the resize unit modules.
`ifndef HORIZONTAL_POLYPHASE_RESIZE_UNIT_ASSERT_SVH
`define HORIZONTAL_POLYPHASE_RESIZE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HPR_ASSERT_IMP(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HPR_ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) \
		else $error(msg);

`endif

FILE: rtl/hpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hpr_pkg;

	typedef enum logic [1:0] {
		OP_LOAD_PIXEL = 2'd0,
		OP_LOAD_COEFF = 2'd1,
		OP_LOAD_START = 2'd2,
		OP_COMPUTE    = 2'd3
	} op_t;

	localparam logic [1:0] CFG_TAP_COUNT  = 2'd0;
	localparam logic [1:0] CFG_PIXEL_MAX  = 2'd1;
	localparam logic [1:0] CFG_LINE_WIDTH = 2'd2;

	localparam logic [4:0]  TAP_COUNT_RESET  = 5'd1;
	localparam logic [15:0] PIXEL_MAX_RESET  = 16'hFFFF;
	localparam logic [11:0] LINE_WIDTH_RESET = 12'd2048;

	localparam int          FRAC_BITS  = 14;
	localparam logic [31:0] ROUND_BIAS = 32'd8192;
	localparam logic [15:0] PIX_OFFSET = 16'h8000;

	typedef struct packed {
		logic accept;
		logic issue;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic compute_ok;
		logic more_taps;
		logic last_tap;
	} status_t;

endpackage

`default_nettype wire

FILE: rtl/hpr_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

`include "horizontal_polyphase_resize_unit_assert.svh"

module hpr_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire hpr_pkg::status_t status,
	output hpr_pkg::cmd_t         cmd,
	output logic                  busy
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   drain_q;
	logic   busy_q;

	always_comb begin
		cmd.accept = start && !busy_q;
		cmd.issue  = (state_q == ST_RUN) && status.more_taps;
		cmd.finish = (state_q == ST_FINISH);
	end

	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			drain_q <= 1'b0;
			busy_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.accept && status.compute_ok) begin
						state_q <= ST_RUN;
						busy_q  <= 1'b1;
					end
				end
				ST_RUN: begin
					if (status.last_tap) begin
						state_q <= ST_DRAIN;
						drain_q <= 1'b0;
					end
				end
				ST_DRAIN: begin
					if (drain_q) begin
						state_q <= ST_FINISH;
					end else begin
						drain_q <= 1'b1;
					end
				end
				ST_FINISH: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	`HPR_ASSERT_NEXT(a_compute_sets_busy, clk, arst_n, cmd.accept && status.compute_ok, busy_q, "compute item did not raise busy")
	`HPR_ASSERT_NEXT(a_finish_clears_busy, clk, arst_n, cmd.finish, !busy_q, "busy held after finish")
	`HPR_ASSERT_IMP(a_busy_matches_state, clk, arst_n, 1'b1, busy_q == (state_q != ST_IDLE), "busy out of step with state")

endmodule

`default_nettype wire

FILE: rtl/hpr_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

`include "horizontal_polyphase_resize_unit_assert.svh"

module hpr_datapath #(
	parameter int LINE_DEPTH = 2048,
	parameter int OUT_DEPTH  = 2048,
	parameter int MAX_TAPS   = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire hpr_pkg::cmd_t      cmd,
	output hpr_pkg::status_t        status,
	input  wire logic [1:0]         op,
	input  wire logic [10:0]        pos,
	input  wire logic [3:0]         tap,
	input  wire logic [15:0]        pixel,
	input  wire logic signed [15:0] coeff,
	input  wire logic [10:0]        start_req,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	output logic                    done,
	output logic [10:0]             out_index,
	output logic [15:0]             pixel_out
);

	localparam int LW  = $clog2(LINE_DEPTH);
	localparam int OW  = $clog2(OUT_DEPTH);
	localparam int CAW = $clog2(OUT_DEPTH * MAX_TAPS);
	localparam int KW  = $clog2(MAX_TAPS + 1);
	localparam int LXW = (LW > 11) ? LW : 11;
	localparam int OXW = (OW > 11) ? OW : 11;
	localparam int IW  = (LW > 12) ? LW : 12;
	localparam int WXW = (LW + 1 > 12) ? LW + 1 : 12;
	localparam int TXW = (KW > 5) ? KW : 5;

	logic [4:0]  tap_count_q;
	logic [15:0] pixel_max_q;
	logic [11:0] line_width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q  <= hpr_pkg::TAP_COUNT_RESET;
			pixel_max_q  <= hpr_pkg::PIXEL_MAX_RESET;
			line_width_q <= hpr_pkg::LINE_WIDTH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hpr_pkg::CFG_TAP_COUNT:  tap_count_q  <= cfg_data[4:0];
				hpr_pkg::CFG_PIXEL_MAX:  pixel_max_q  <= cfg_data;
				hpr_pkg::CFG_LINE_WIDTH: line_width_q <= cfg_data[11:0];
				default: begin
				end
			endcase
		end
	end

	logic [TXW-1:0] tc_x;
	logic [KW-1:0]  taps;
	logic [WXW-1:0] lw_x;
	logic [WXW-1:0] lw_m1;
	logic [LW-1:0]  width_m1;

	always_comb begin
		tc_x  = TXW'(tap_count_q);
		lw_x  = WXW'(line_width_q);
		lw_m1 = lw_x - WXW'(1);
		if (tc_x > TXW'(MAX_TAPS)) begin
			taps = KW'(MAX_TAPS);
		end else begin
			taps = tc_x[KW-1:0];
		end
		priority if (lw_x == '0) begin
			width_m1 = '0;
		end else if (lw_x > WXW'(LINE_DEPTH)) begin
			width_m1 = LW'(LINE_DEPTH - 1);
		end else begin
			width_m1 = lw_m1[LW-1:0];
		end
	end

	logic [OXW-1:0] pos_x;
	logic [LXW-1:0] line_pos_x;
	logic           pos_out_ok;
	logic           line_we;
	logic           coeff_we;
	logic           start_we;
	logic           start_rd;
	logic [CAW-1:0] coeff_waddr;

	always_comb begin
		pos_x       = OXW'(pos);
		line_pos_x  = LXW'(pos);
		pos_out_ok  = 32'(pos) < OUT_DEPTH;
		line_we     = cmd.accept && (op == hpr_pkg::OP_LOAD_PIXEL) && (32'(pos) < LINE_DEPTH);
		coeff_we    = cmd.accept && (op == hpr_pkg::OP_LOAD_COEFF) && pos_out_ok
			&& (32'(tap) < MAX_TAPS);
		start_we    = cmd.accept && (op == hpr_pkg::OP_LOAD_START) && pos_out_ok;
		start_rd    = cmd.accept && (op == hpr_pkg::OP_COMPUTE) && pos_out_ok;
		coeff_waddr = CAW'(pos_x[OW-1:0]) * CAW'(MAX_TAPS) + CAW'(tap);
	end

	logic [10:0]    pos_q;
	logic [CAW-1:0] coeff_base_q;
	logic [KW-1:0]  tap_q;
	logic [10:0]    start_q;

	always_ff @(posedge clk) begin
		if (start_rd) begin
			pos_q        <= pos;
			coeff_base_q <= CAW'(pos_x[OW-1:0]) * CAW'(MAX_TAPS);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
		end else if (start_rd) begin
			tap_q <= '0;
		end else if (cmd.issue) begin
			tap_q <= tap_q + KW'(1);
		end
	end

	always_comb begin
		status.compute_ok = (op == hpr_pkg::OP_COMPUTE) && pos_out_ok;
		status.more_taps  = tap_q < taps;
		status.last_tap   = ({1'b0, tap_q} + (KW + 1)'(1)) >= {1'b0, taps};
	end

	logic [10:0] start_mem [OUT_DEPTH];

	always_ff @(posedge clk) begin
		if (start_we) begin
			start_mem[pos_x[OW-1:0]] <= start_req;
		end
		if (start_rd) begin
			start_q <= start_mem[pos_x[OW-1:0]];
		end
	end

	logic [IW-1:0]  idx_sum;
	logic [LW-1:0]  line_raddr;
	logic [CAW-1:0] coeff_raddr;

	always_comb begin
		idx_sum = IW'(start_q) + IW'(tap_q);
		if (idx_sum > IW'(width_m1)) begin
			line_raddr = width_m1;
		end else begin
			line_raddr = idx_sum[LW-1:0];
		end
		coeff_raddr = coeff_base_q + CAW'(tap_q);
	end

	logic [15:0] line_mem [LINE_DEPTH];
	logic [15:0] px_s1;

	always_ff @(posedge clk) begin
		if (line_we) begin
			line_mem[line_pos_x[LW-1:0]] <= pixel;
		end
		if (cmd.issue) begin
			px_s1 <= line_mem[line_raddr];
		end
	end

	logic signed [15:0] coeff_mem [OUT_DEPTH * MAX_TAPS];
	logic signed [15:0] coeff_s1;

	always_ff @(posedge clk) begin
		if (coeff_we) begin
			coeff_mem[coeff_waddr] <= coeff;
		end
		if (cmd.issue) begin
			coeff_s1 <= coeff_mem[coeff_raddr];
		end
	end

	logic               vld_s1;
	logic               vld_s2;
	logic signed [15:0] px_c_s1;
	logic signed [31:0] prod_s2;
	logic [31:0]        acc_q;

	assign px_c_s1 = signed'(px_s1 ^ hpr_pkg::PIX_OFFSET);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			prod_s2 <= coeff_s1 * px_c_s1;
		end
		if (start_rd) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + unsigned'(prod_s2);
		end
	end

	logic [31:0]        rnd;
	logic signed [17:0] shifted;
	logic signed [15:0] sat;
	logic signed [15:0] cap;
	logic signed [15:0] capped;

	always_comb begin
		rnd     = acc_q + hpr_pkg::ROUND_BIAS;
		shifted = signed'(rnd[31:hpr_pkg::FRAC_BITS]);
		priority if (shifted > 18'sd32767) begin
			sat = 16'sh7FFF;
		end else if (shifted < -18'sd32768) begin
			sat = -16'sh8000;
		end else begin
			sat = shifted[15:0];
		end
		cap = signed'(pixel_max_q ^ hpr_pkg::PIX_OFFSET);
		if (sat > cap) begin
			capped = cap;
		end else begin
			capped = sat;
		end
	end

	logic        done_q;
	logic [10:0] out_index_q;
	logic [15:0] pixel_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_index_q <= pos_q;
			pixel_out_q <= unsigned'(capped) ^ hpr_pkg::PIX_OFFSET;
		end
	end

	assign done      = done_q;
	assign out_index = out_index_q;
	assign pixel_out = pixel_out_q;

	`HPR_ASSERT_IMP(a_accept_pipe_empty, clk, arst_n, cmd.accept, !vld_s1 && !vld_s2, "item accepted while taps in flight")
	`HPR_ASSERT_IMP(a_finish_pipe_empty, clk, arst_n, cmd.finish, !vld_s1 && !vld_s2 && !cmd.issue, "finish before accumulator drained")

endmodule

`default_nettype wire

FILE: rtl/horizontal_polyphase_resize_unit.sv
// Load items (pixel, coefficient, start position) never raise busy.
// A compute item raises busy, steps through the RUN, DRAIN and FINISH states, then strobes done from a register;
// it uses T = min(tap_count, MAX_TAPS) taps; the single shared multiply-accumulate takes one tap a cycle.
// The next item is taken in the cycle the result is shown, not before the last compute item is through.
// The receiver cannot stall; done lasts exactly one cycle.
// arst_n clears control and configuration; the line, coefficient and start stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module horizontal_polyphase_resize_unit #(
	parameter int LINE_DEPTH = 2048,
	parameter int OUT_DEPTH  = 2048,
	parameter int MAX_TAPS   = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	output logic                    busy,
	input  wire logic [1:0]         op,
	input  wire logic [10:0]        pos,
	input  wire logic [3:0]         tap,
	input  wire logic [15:0]        pixel,
	input  wire logic signed [15:0] coeff,
	input  wire logic [10:0]        start_req,
	input  wire logic               cfg_we,
	input  wire logic [1:0]         cfg_index,
	input  wire logic [15:0]        cfg_data,
	output logic                    done,
	output logic [10:0]             out_index,
	output logic [15:0]             pixel_out
);

	hpr_pkg::cmd_t    cmd;
	hpr_pkg::status_t status;

	hpr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	hpr_datapath #(
		.LINE_DEPTH (LINE_DEPTH),
		.OUT_DEPTH  (OUT_DEPTH),
		.MAX_TAPS   (MAX_TAPS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.op        (op),
		.pos       (pos),
		.tap       (tap),
		.pixel     (pixel),
		.coeff     (coeff),
		.start_req (start_req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.done      (done),
		.out_index (out_index),
		.pixel_out (pixel_out)
	);

endmodule

`default_nettype wire

FILE: tb/sv/resize_checker.sv
`timescale 1ns / 1ps

module resize_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  op,
	input  logic [10:0] pos,
	input  logic [3:0]  tap,
	input  logic [15:0] pixel,
	input  logic [15:0] coeff,
	input  logic [10:0] start_req,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        done,
	input  logic [10:0] out_index,
	input  logic [15:0] pixel_out,
	input  logic        end_check,
	output int          mismatches,
	output int          outstanding
);
	import hpr_pkg::*;

	localparam int LINE_DEPTH = 2048;
	localparam int MAX_TAPS   = 16;

	logic [15:0]        line_mem  [0:2047];
	logic signed [15:0] coef_mem  [0:32767];
	logic [10:0]        start_mem [0:2047];

	logic [4:0]  taps_cfg;
	logic [15:0] pmax_cfg;
	logic [11:0] width_cfg;

	logic [10:0] exp_index_q [$];
	logic [15:0] exp_pixel_q [$];
	logic [10:0] want_index;
	logic [15:0] want_pixel;
	int          err_count;
	bit          end_done;

	task automatic log_mismatch(input string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		err_count++;
	endtask

	function automatic logic [15:0] filtered_pixel(input logic [10:0] opos);
		int taps;
		int width;
		int idx;
		int k;
		int sample;
		int weight;
		int level;
		int ceiling;
		logic [31:0] acc;
		taps = (taps_cfg > MAX_TAPS) ? MAX_TAPS : int'(taps_cfg);
		width = (width_cfg == 0) ? 1 : int'(width_cfg);
		if (width > LINE_DEPTH) width = LINE_DEPTH;
		acc = '0;
		for (k = 0; k < taps; k++) begin
			idx = int'(start_mem[opos]) + k;
			if (idx > width - 1) idx = width - 1;
			sample = int'(line_mem[idx]) - int'(PIX_OFFSET);
			weight = int'(coef_mem[int'(opos) * MAX_TAPS + k]);
			acc = acc + sample * weight;
		end
		acc = acc + ROUND_BIAS;
		level = $signed(acc) >>> FRAC_BITS;
		if (level > 32767) level = 32767;
		if (level < -32768) level = -32768;
		ceiling = int'(pmax_cfg) - int'(PIX_OFFSET);
		if (level > ceiling) level = ceiling;
		level = level + int'(PIX_OFFSET);
		return level[15:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_cfg = TAP_COUNT_RESET;
			pmax_cfg = PIXEL_MAX_RESET;
			width_cfg = LINE_WIDTH_RESET;
			exp_index_q.delete();
			exp_pixel_q.delete();
			err_count = 0;
			end_done = 1'b0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (done) begin
				if (exp_index_q.size() == 0) begin
					log_mismatch($sformatf("result index %0d pixel %0d with none expected",
						out_index, pixel_out));
				end else begin
					want_index = exp_index_q.pop_front();
					want_pixel = exp_pixel_q.pop_front();
					if (out_index !== want_index)
						log_mismatch($sformatf("out_index %0d, expected %0d",
							out_index, want_index));
					if (pixel_out !== want_pixel)
						log_mismatch($sformatf("pixel_out %0d for output %0d, expected %0d",
							pixel_out, want_index, want_pixel));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_TAP_COUNT:  taps_cfg = cfg_data[4:0];
					CFG_PIXEL_MAX:  pmax_cfg = cfg_data;
					CFG_LINE_WIDTH: width_cfg = cfg_data[11:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				case (op)
					OP_LOAD_PIXEL: line_mem[pos] = pixel;
					OP_LOAD_COEFF: coef_mem[int'(pos) * MAX_TAPS + int'(tap)] = coeff;
					OP_LOAD_START: start_mem[pos] = start_req;
					OP_COMPUTE: begin
						exp_index_q.push_back(pos);
						exp_pixel_q.push_back(filtered_pixel(pos));
					end
					default: ;
				endcase
			end
			if (end_check && !end_done) begin
				end_done = 1'b1;
				if (exp_index_q.size() != 0)
					log_mismatch($sformatf("%0d results never arrived", exp_index_q.size()));
			end
			mismatches <= err_count;
			outstanding <= exp_index_q.size();
		end
	end

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import hpr_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	op_t         op;
	logic [10:0] pos;
	logic [3:0]  tap;
	logic [15:0] pixel;
	logic signed [15:0] coeff;
	logic [10:0] start_req;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        done;
	logic [10:0] out_index;
	logic [15:0] pixel_out;
	logic        end_check;
	int          mismatches;
	int          outstanding;

	int          idle_pct;
	int          items_sent;
	logic [4:0]  cur_taps;
	logic [11:0] cur_width;
	bit          pix_ok   [0:2047];
	bit          start_ok [0:2047];
	bit          coef_ok  [0:32767];
	logic [10:0] start_val [0:2047];

	horizontal_polyphase_resize_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.op        (op),
		.pos       (pos),
		.tap       (tap),
		.pixel     (pixel),
		.coeff     (coeff),
		.start_req (start_req),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.done      (done),
		.out_index (out_index),
		.pixel_out (pixel_out)
	);

	resize_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.pos         (pos),
		.tap         (tap),
		.pixel       (pixel),
		.coeff       (coeff),
		.start_req   (start_req),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.done        (done),
		.out_index   (out_index),
		.pixel_out   (pixel_out),
		.end_check   (end_check),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic send_item(input op_t o, input logic [10:0] p, input logic [3:0] t,
			input logic [15:0] px, input logic [15:0] c, input logic [10:0] s);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(0, 99) < idle_pct) gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		op <= o;
		pos <= p;
		tap <= t;
		pixel <= px;
		coeff <= c;
		start_req <= s;
		@(posedge clk);
		while (busy) @(posedge clk);
		case (o)
			OP_LOAD_PIXEL: pix_ok[p] = 1'b1;
			OP_LOAD_COEFF: coef_ok[{p, t}] = 1'b1;
			OP_LOAD_START: begin
				start_ok[p] = 1'b1;
				start_val[p] = s;
			end
			default: ;
		endcase
		items_sent++;
	endtask

	task automatic compute(input logic [10:0] p);
		send_item(OP_COMPUTE, p, 4'($urandom), 16'($urandom), 16'($urandom), 11'($urandom));
	endtask

	task automatic settle();
		int waited;
		waited = 0;
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (24) @(posedge clk);
	endtask

	task automatic set_reg(input logic [1:0] idx, input logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == CFG_TAP_COUNT) cur_taps = data[4:0];
		if (idx == CFG_LINE_WIDTH) cur_width = data[11:0];
	endtask

	task automatic reconfigure();
		logic [15:0] junk;
		logic [4:0]  tc;
		logic [15:0] pm;
		logic [11:0] lw;
		settle();
		junk = 16'($urandom);
		case ($urandom_range(0, 9))
			0: tc = 5'd0;
			1: tc = 5'd1;
			2: tc = 5'd16;
			3: tc = 5'(17 + $urandom_range(0, 14));
			default: tc = 5'($urandom_range(1, 16));
		endcase
		case ($urandom_range(0, 9))
			0: pm = 16'd0;
			1: pm = 16'd1;
			2: pm = 16'd32767;
			3: pm = 16'd32768;
			4, 5: pm = 16'hFFFF;
			default: pm = 16'($urandom);
		endcase
		case ($urandom_range(0, 9))
			0: lw = 12'd0;
			1: lw = 12'd1;
			2: lw = 12'd2048;
			3: lw = 12'(2049 + $urandom_range(0, 2046));
			4, 5: lw = 12'($urandom_range(1, 16));
			default: lw = 12'($urandom_range(1, 2048));
		endcase
		set_reg(CFG_TAP_COUNT, {junk[15:5], tc});
		set_reg(CFG_PIXEL_MAX, pm);
		set_reg(CFG_LINE_WIDTH, {junk[15:12], lw});
	endtask

	function automatic logic [10:0] pick_start(input int width);
		case ($urandom_range(0, 3))
			0: return 11'($urandom);
			1: return 11'(2047 - $urandom_range(0, 7));
			default: return 11'($urandom_range(0, width - 1));
		endcase
	endfunction

	function automatic logic [15:0] pick_coeff();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2, 3: return 16'($urandom);
			default: return 16'(int'($urandom_range(0, 24576)) - 4096);
		endcase
	endfunction

	function automatic logic [15:0] pick_pixel();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [10:0] pick_pos();
		case ($urandom_range(0, 5))
			0, 1, 2: return 11'($urandom_range(0, 15));
			3: return 11'(2047 - $urandom_range(0, 3));
			default: return 11'($urandom);
		endcase
	endfunction

	// Loads whatever the output's window still lacks (and, when refresh is set, rewrites
	// part of it with new content), then computes the output.
	task automatic prime_output(input logic [10:0] p, input bit refresh);
		int taps;
		int width;
		int k;
		int idx;
		taps = (cur_taps > 16) ? 16 : int'(cur_taps);
		width = (cur_width == 0) ? 1 : int'(cur_width);
		if (width > 2048) width = 2048;
		if (!start_ok[p] || (refresh && $urandom_range(0, 2) == 0))
			send_item(OP_LOAD_START, p, 4'($urandom), 16'($urandom), 16'($urandom),
				pick_start(width));
		for (k = 0; k < taps; k++) begin
			if (!coef_ok[{p, k[3:0]}] || (refresh && $urandom_range(0, 1) == 0))
				send_item(OP_LOAD_COEFF, p, k[3:0], 16'($urandom), pick_coeff(),
					11'($urandom));
		end
		for (k = 0; k < taps; k++) begin
			idx = int'(start_val[p]) + k;
			if (idx > width - 1) idx = width - 1;
			if (!pix_ok[idx] || (refresh && $urandom_range(0, 2) == 0))
				send_item(OP_LOAD_PIXEL, idx[10:0], 4'($urandom), pick_pixel(),
					16'($urandom), 11'($urandom));
		end
		compute(p);
	endtask

	initial begin
		int phase;
		int goal;
		int choice;
		arst_n = 1'b0;
		start = 1'b0;
		op = OP_LOAD_PIXEL;
		pos = '0;
		tap = '0;
		pixel = '0;
		coeff = '0;
		start_req = '0;
		cfg_we = 1'b0;
		cfg_index = CFG_TAP_COUNT;
		cfg_data = '0;
		end_check = 1'b0;
		idle_pct = 0;
		items_sent = 0;
		cur_taps = TAP_COUNT_RESET;
		cur_width = LINE_WIDTH_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Saturation at both ends, highest tap, and the register corner cases.
		send_item(OP_LOAD_PIXEL, 11'd0, 4'd0, 16'h0000, 16'h0000, 11'd0);
		send_item(OP_LOAD_PIXEL, 11'd2047, 4'd15, 16'hFFFF, 16'hFFFF, 11'd2047);
		send_item(OP_LOAD_START, 11'd0, 4'd0, 16'h0000, 16'h0000, 11'd0);
		send_item(OP_LOAD_COEFF, 11'd0, 4'd0, 16'h0000, 16'h7FFF, 11'd0);
		compute(11'd0);
		send_item(OP_LOAD_COEFF, 11'd0, 4'd0, 16'h0000, 16'h8000, 11'd0);
		compute(11'd0);
		send_item(OP_LOAD_START, 11'd2047, 4'd0, 16'h0000, 16'h0000, 11'd2047);
		send_item(OP_LOAD_COEFF, 11'd2047, 4'd15, 16'h0000, 16'h8000, 11'd0);
		settle();
		set_reg(CFG_TAP_COUNT, 16'd31);
		set_reg(CFG_LINE_WIDTH, 16'd4095);
		prime_output(11'd2047, 1'b0);
		settle();
		set_reg(CFG_TAP_COUNT, 16'd0);
		compute(11'd0);
		settle();
		set_reg(CFG_TAP_COUNT, 16'd1);
		set_reg(CFG_PIXEL_MAX, 16'd1);
		compute(11'd0);
		settle();
		set_reg(CFG_PIXEL_MAX, 16'hFFFF);
		set_reg(CFG_LINE_WIDTH, 16'd0);
		compute(11'd2047);

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				1: idle_pct = 74;
				3: idle_pct = 13;
				default: idle_pct = 0;
			endcase
			reconfigure();
			goal = items_sent + 150;
			while (items_sent < goal) begin
				choice = $urandom_range(0, 9);
				if (choice < 6)
					prime_output(pick_pos(), 1'b1);
				else if (choice < 8)
					prime_output(pick_pos(), 1'b0);
				else
					send_item(op_t'($urandom_range(0, 2)), 11'($urandom), 4'($urandom),
						16'($urandom), 16'($urandom), 11'($urandom));
				if ($urandom_range(0, 39) == 0) reconfigure();
			end
		end

		settle();
		end_check <= 1'b1;
		@(posedge clk);
		@(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

FILE: horizontal_polyphase_resize_unit.f
+incdir+rtl
rtl/hpr_pkg.sv
rtl/hpr_ctrl.sv
rtl/hpr_datapath.sv
rtl/horizontal_polyphase_resize_unit.sv
tb/sv/resize_checker.sv
tb/sv/testbench.sv
